// ===== hdl/nss_pkg.sv =====
// Shared types, codes and constants for the scatter store.
// Used by every module of the block; depends on nothing else.
package nss_pkg;

  localparam int DEF_STORE_DEPTH = 4096;
  localparam int DEF_ELEM_WIDTH  = 32;
  localparam int DEF_MAX_RANK    = 4;

  localparam int NUM_DIMS  = 4;
  localparam int RANK_W    = 3;
  localparam int DIM_W     = 13;
  localparam int CIDX_W    = 3;
  localparam int ADDR_IN_W = 12;
  localparam int POS_W     = 12;
  localparam int VAL_W     = 32;
  localparam int INDEX_W   = 64;

  // Strides saturate above the largest store, so the products stay narrow.
  localparam int MAX_STORE_DEPTH = 1048576;
  localparam int STRIDE_W        = $clog2(MAX_STORE_DEPTH) + 2;
  localparam int PROD_W          = DIM_W + STRIDE_W;
  localparam int BASE_W          = PROD_W + 2;
  localparam int LIM_W           = BASE_W + 1;

  // Queue between front and back; pointers wrap naturally at this power of two.
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QLEVEL_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    REQ_LOAD,
    REQ_SCATTER,
    REQ_READ
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_RANGE,
    ST_INVALID
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ
  } op_kind_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_DATA_RANK,
    CFG_INDEX_DEPTH,
    CFG_DIM0,
    CFG_DIM1,
    CFG_DIM2,
    CFG_DIM3
  } cfg_reg_t;

  typedef struct packed {
    logic                                busy;
    logic                                ok;
    logic [RANK_W-1:0]                   depth;
    logic [NUM_DIMS-1:0][DIM_W-1:0]      dim;
    logic [NUM_DIMS-1:0][STRIDE_W-1:0]   stride;
  } geo_t;

  function automatic logic [STRIDE_W-1:0] stride_sat(input logic [PROD_W-1:0] p);
    logic [STRIDE_W-1:0] r;
    if (p[PROD_W-1:STRIDE_W] != '0) begin
      r = '1;
    end else begin
      r = p[STRIDE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/nd_scatter_store.sv =====
// Top level of the N-dimensional scatter store: config unit, front end,
// operation queue and back end. Depends on nss_pkg and all nss_* modules.
//
//   channel  direction  handshake              beat contents
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   in       in         in_valid / in_stall    req_type .. slice_position
//   out      out        out_valid / out_stall  read_value, status
//
// One result beat per request, in order, via stage 1, stage 2, the queue and
// result register. Sustained rate is one request per cycle while out_stall is
// low and no strides rebuild; in_stall rises once queue level plus front stages
// reach the four-entry queue's depth. After each config write in_stall holds
// while the row-major strides are built. Synchronous reset clears control only;
// the tensor memory has no clearing pass and reads garbage until written.
module nd_scatter_store #(
  parameter int STORE_DEPTH = nss_pkg::DEF_STORE_DEPTH,
  parameter int ELEM_WIDTH  = nss_pkg::DEF_ELEM_WIDTH,
  parameter int MAX_RANK    = nss_pkg::DEF_MAX_RANK
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [nss_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [nss_pkg::DIM_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         req_type,
  input  logic [nss_pkg::ADDR_IN_W-1:0]      elem_address,
  input  logic [nss_pkg::VAL_W-1:0]          elem_value,
  input  logic signed [nss_pkg::INDEX_W-1:0] index_0,
  input  logic signed [nss_pkg::INDEX_W-1:0] index_1,
  input  logic signed [nss_pkg::INDEX_W-1:0] index_2,
  input  logic signed [nss_pkg::INDEX_W-1:0] index_3,
  input  logic [nss_pkg::POS_W-1:0]          slice_position,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [nss_pkg::VAL_W-1:0]          read_value,
  output logic [1:0]                         status
);
  import nss_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int QW = 2 + 2 + AW + VAL_W;

  geo_t                geo;
  logic                q_push;
  op_kind_t            push_kind;
  status_t             push_status;
  logic [AW-1:0]       push_addr;
  logic [VAL_W-1:0]    push_data;
  logic                q_pop;
  logic                q_valid;
  logic [QW-1:0]       q_head;
  logic [QLEVEL_W-1:0] q_level;

  nss_cfg #(
    .MAX_RANK (MAX_RANK)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geo       (geo)
  );

  nss_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .geo            (geo),
    .q_level        (q_level),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .elem_address   (elem_address),
    .elem_value     (elem_value),
    .index_0        (index_0),
    .index_1        (index_1),
    .index_2        (index_2),
    .index_3        (index_3),
    .slice_position (slice_position),
    .push           (q_push),
    .push_kind      (push_kind),
    .push_status    (push_status),
    .push_addr      (push_addr),
    .push_data      (push_data)
  );

  nss_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry ({push_kind, push_status, push_addr, push_data}),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head),
    .level      (q_level)
  );

  nss_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .ELEM_WIDTH  (ELEM_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (q_valid),
    .op_kind    (op_kind_t'(q_head[QW-1:QW-2])),
    .op_status  (status_t'(q_head[QW-3:QW-4])),
    .op_addr    (q_head[VAL_W+AW-1:VAL_W]),
    .op_data    (q_head[VAL_W-1:0]),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .status     (status)
  );

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && !q_pop && q_level == QLEVEL_W'(QDEPTH)))
    else $error("operation queue overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_level != '0)
    else $error("pop from empty operation queue");

  a_cfg_holds_input: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> in_stall)
    else $error("request taken while strides rebuild");

endmodule

// ===== hdl/nss_cfg.sv =====
// Configuration registers and row-major stride builder.
// Depends on nss_pkg; feeds the geometry struct to the front.
module nss_cfg #(
  parameter int MAX_RANK = nss_pkg::DEF_MAX_RANK
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [nss_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [nss_pkg::DIM_W-1:0]   cfg_data,
  output nss_pkg::geo_t               geo
);
  import nss_pkg::*;

  localparam int RANK_LIMIT = (MAX_RANK < NUM_DIMS) ? MAX_RANK : NUM_DIMS;

  logic [RANK_W-1:0]                 data_rank;
  logic [RANK_W-1:0]                 index_depth;
  logic [NUM_DIMS-1:0][DIM_W-1:0]    dim_size;
  logic [NUM_DIMS-1:0][STRIDE_W-1:0] stride;
  logic [1:0]                        settle;
  logic [NUM_DIMS-1:0][DIM_W-1:0]    eff;
  logic                              cfg_ok;
  logic                              cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Dimensions beyond rank count as extent one.
  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      eff[d] = (RANK_W'(d) < data_rank) ? dim_size[d] : DIM_W'(1);
    end
  end

  always_comb begin
    cfg_ok = (data_rank >= RANK_W'(1)) && (data_rank <= RANK_W'(RANK_LIMIT)) &&
             (index_depth >= RANK_W'(1)) && (index_depth <= data_rank);
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (RANK_W'(d) < data_rank && dim_size[d] == '0) begin
        cfg_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_rank   <= RANK_W'(1);
      index_depth <= RANK_W'(1);
      for (int d = 0; d < NUM_DIMS; d++) begin
        dim_size[d] <= DIM_W'(1);
        stride[d]   <= STRIDE_W'(1);
      end
      settle <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          CFG_DATA_RANK:   data_rank   <= cfg_data[RANK_W-1:0];
          CFG_INDEX_DEPTH: index_depth <= cfg_data[RANK_W-1:0];
          CFG_DIM0:        dim_size[0] <= cfg_data;
          CFG_DIM1:        dim_size[1] <= cfg_data;
          CFG_DIM2:        dim_size[2] <= cfg_data;
          CFG_DIM3:        dim_size[3] <= cfg_data;
          default: ;
        endcase
        settle <= 2'd3;
      end else if (settle != '0) begin
        settle <= settle - 2'd1;
      end
      // Build strides from the innermost dimension out, one product a cycle.
      case (settle)
        2'd3: stride[2] <= stride_sat(PROD_W'(eff[3]));
        2'd2: stride[1] <= stride_sat(PROD_W'(eff[2]) * PROD_W'(stride[2]));
        2'd1: stride[0] <= stride_sat(PROD_W'(eff[1]) * PROD_W'(stride[1]));
        default: ;
      endcase
      stride[3] <= STRIDE_W'(1);
    end
  end

  always_comb begin
    geo.busy   = (settle != '0);
    geo.ok     = cfg_ok;
    geo.depth  = index_depth;
    geo.dim    = dim_size;
    geo.stride = stride;
  end

endmodule

// ===== hdl/nss_front.sv =====
// Front end: accepts requests, checks indices, forms the element address
// and classifies each request into a store operation. Depends on nss_pkg.
module nss_front #(
  parameter int STORE_DEPTH = nss_pkg::DEF_STORE_DEPTH,
  localparam int AW         = $clog2(STORE_DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  nss_pkg::geo_t                     geo,
  input  logic [nss_pkg::QLEVEL_W-1:0]      q_level,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        req_type,
  input  logic [nss_pkg::ADDR_IN_W-1:0]     elem_address,
  input  logic [nss_pkg::VAL_W-1:0]         elem_value,
  input  logic signed [nss_pkg::INDEX_W-1:0] index_0,
  input  logic signed [nss_pkg::INDEX_W-1:0] index_1,
  input  logic signed [nss_pkg::INDEX_W-1:0] index_2,
  input  logic signed [nss_pkg::INDEX_W-1:0] index_3,
  input  logic [nss_pkg::POS_W-1:0]         slice_position,
  output logic                              push,
  output nss_pkg::op_kind_t                 push_kind,
  output nss_pkg::status_t                  push_status,
  output logic [AW-1:0]                     push_addr,
  output logic [nss_pkg::VAL_W-1:0]         push_data
);
  import nss_pkg::*;

  logic                  accept;
  logic [INDEX_W-1:0]    idx [NUM_DIMS];
  logic [NUM_DIMS-1:0][PROD_W-1:0] prod_next;
  logic                  idx_bad_next;
  logic [BASE_W-1:0]     base_next;
  logic [QLEVEL_W-1:0]   in_flight;

  // Stage 1 registers
  logic                  s1_valid;
  logic [1:0]            s1_req;
  logic                  s1_in_range;
  logic [ADDR_IN_W-1:0]  s1_addr;
  logic [VAL_W-1:0]      s1_data;
  logic [POS_W-1:0]      s1_pos;
  logic [STRIDE_W-1:0]   s1_slice_len;
  logic                  s1_cfg_ok;
  logic                  s1_idx_bad;
  logic [NUM_DIMS-1:0][PROD_W-1:0] s1_prod;

  // Stage 2 registers
  logic                  s2_valid;
  logic [1:0]            s2_req;
  logic                  s2_in_range;
  logic [ADDR_IN_W-1:0]  s2_addr;
  logic [VAL_W-1:0]      s2_data;
  logic [POS_W-1:0]      s2_pos;
  logic [STRIDE_W-1:0]   s2_slice_len;
  logic                  s2_cfg_ok;
  logic                  s2_idx_bad;
  logic [BASE_W-1:0]     s2_base;

  logic [LIM_W-1:0]      lim;

  // Hold input while strides rebuild or the queue could not take every beat in flight.
  assign in_flight = q_level + QLEVEL_W'(s1_valid) + QLEVEL_W'(s2_valid);
  assign in_stall  = geo.busy || (in_flight >= QLEVEL_W'(QDEPTH));
  assign accept    = in_valid && !in_stall;

  assign idx[0] = index_0;
  assign idx[1] = index_1;
  assign idx[2] = index_2;
  assign idx[3] = index_3;

  always_comb begin
    idx_bad_next = 1'b0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (RANK_W'(d) < geo.depth) begin
        if (idx[d][INDEX_W-1:DIM_W] != '0 || idx[d][DIM_W-1:0] >= geo.dim[d]) begin
          idx_bad_next = 1'b1;
        end
        prod_next[d] = PROD_W'(idx[d][DIM_W-1:0]) * PROD_W'(geo.stride[d]);
      end else begin
        prod_next[d] = '0;
      end
    end
  end

  always_comb begin
    base_next = '0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      base_next = base_next + BASE_W'(s1_prod[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req       <= req_type;
      s1_in_range  <= (32'(elem_address) < 32'(STORE_DEPTH));
      s1_addr      <= elem_address;
      s1_data      <= elem_value;
      s1_pos       <= slice_position;
      s1_slice_len <= geo.stride[2'(geo.depth - RANK_W'(1))];
      s1_cfg_ok    <= geo.ok;
      s1_idx_bad   <= idx_bad_next;
      s1_prod      <= prod_next;
    end
    s2_req       <= s1_req;
    s2_in_range  <= s1_in_range;
    s2_addr      <= s1_addr;
    s2_data      <= s1_data;
    s2_pos       <= s1_pos;
    s2_slice_len <= s1_slice_len;
    s2_cfg_ok    <= s1_cfg_ok;
    s2_idx_bad   <= s1_idx_bad;
    s2_base      <= base_next;
  end

  assign lim = LIM_W'(s2_base) + LIM_W'(s2_slice_len);

  // Classify: the order of checks sets which status wins.
  always_comb begin
    push        = s2_valid;
    push_kind   = OP_NONE;
    push_status = ST_DONE;
    push_addr   = AW'(s2_addr);
    push_data   = s2_data;
    case (req_t'(s2_req))
      REQ_LOAD, REQ_READ: begin
        if (s2_in_range) begin
          push_kind = (req_t'(s2_req) == REQ_LOAD) ? OP_WRITE : OP_READ;
        end else begin
          push_status = ST_RANGE;
        end
      end
      REQ_SCATTER: begin
        if (!s2_cfg_ok) begin
          push_status = ST_INVALID;
        end else if (s2_idx_bad) begin
          push_status = ST_RANGE;
        end else if (STRIDE_W'(s2_pos) >= s2_slice_len) begin
          push_status = ST_INVALID;
        end else if (lim > LIM_W'(STORE_DEPTH)) begin
          push_status = ST_RANGE;
        end else begin
          push_kind = OP_WRITE;
          push_addr = AW'(s2_base + BASE_W'(s2_pos));
        end
      end
      default: begin
        push_status = ST_INVALID;
      end
    endcase
  end

endmodule

// ===== hdl/nss_queue.sv =====
// Short FIFO of classified operations between front and back.
// Depends on nss_pkg for its depth.
module nss_queue #(
  parameter int WIDTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [WIDTH-1:0]              push_entry,
  input  logic                          pop,
  output logic                          head_valid,
  output logic [WIDTH-1:0]              head_entry,
  output logic [nss_pkg::QLEVEL_W-1:0]  level
);
  import nss_pkg::*;

  logic [WIDTH-1:0]    entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QLEVEL_W-1:0] level_next;

  assign head_valid = (level != '0);
  assign head_entry = entries[rd_ptr];
  assign level_next = level + QLEVEL_W'(push) - QLEVEL_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== hdl/nss_back.sv =====
// Back end: owns the tensor memory, carries out writes and reads and
// holds the result beat until taken. Depends on nss_pkg.
module nss_back #(
  parameter int STORE_DEPTH = nss_pkg::DEF_STORE_DEPTH,
  parameter int ELEM_WIDTH  = nss_pkg::DEF_ELEM_WIDTH,
  localparam int AW         = $clog2(STORE_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       op_valid,
  input  nss_pkg::op_kind_t          op_kind,
  input  nss_pkg::status_t           op_status,
  input  logic [AW-1:0]              op_addr,
  input  logic [nss_pkg::VAL_W-1:0]  op_data,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [nss_pkg::VAL_W-1:0]  read_value,
  output logic [1:0]                 status
);
  import nss_pkg::*;

  logic [ELEM_WIDTH-1:0] mem [STORE_DEPTH];
  logic [ELEM_WIDTH-1:0] rdata;
  status_t               status_r;

  // Advance only when the result register is empty or being taken.
  assign pop = op_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (op_kind == OP_WRITE) begin
        mem[op_addr] <= ELEM_WIDTH'(op_data);
      end
      if (op_kind == OP_READ) begin
        rdata <= mem[op_addr];
      end else begin
        rdata <= '0;
      end
      status_r <= op_status;
    end
  end

  assign read_value = VAL_W'(rdata);
  assign status     = status_r;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for nd_scatter_store: directed table, then random load,
// scatter, read and bad-type traffic under several shapes, with random idling.
// Depends on nss_pkg and the nd_scatter_store RTL.
`timescale 1ns / 1ps

module testbench;
  import nss_pkg::*;

  localparam int STORE_DEPTH    = DEF_STORE_DEPTH;
  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 155;
  localparam int SQUEEZE_PHASE  = 5;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int QUIET_LIMIT    = 2000;
  localparam int TAIL_CYCLES    = 10;

  localparam logic [1:0]  REQ_BAD  = 2'd3;
  localparam logic [63:0] NEG_ONE  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [1:0]  kind;
    logic [11:0] addr;
    logic [31:0] val;
    logic [63:0] idx [4];
    logic [11:0] pos;
  } req_beat_t;

  typedef struct {
    logic [31:0] value;
    status_t     code;
  } reply_t;

  typedef struct {
    int        setup;
    req_beat_t beat;
    bit        typed;
    reply_t    want;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid, cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_data;
  logic in_valid, in_stall;
  logic [1:0] req_type;
  logic [ADDR_IN_W-1:0] elem_address;
  logic [VAL_W-1:0] elem_value;
  logic signed [INDEX_W-1:0] index_0, index_1, index_2, index_3;
  logic [POS_W-1:0] slice_position;
  logic out_valid, out_stall;
  logic [VAL_W-1:0] read_value;
  logic [1:0] status;

  // Shadow of the block: tensor contents and the current shape.
  logic [31:0] shadow_mem [STORE_DEPTH];
  bit          mem_loaded [STORE_DEPTH];
  int          loaded_list [$];
  logic [2:0]  geo_rank = 3'd1;
  logic [2:0]  geo_depth = 3'd1;
  logic [12:0] geo_dim [4] = '{13'd1, 13'd1, 13'd1, 13'd1};

  reply_t pending_reply [$];
  reply_t head_reply;
  int     miss_count = 0;
  int     beats_seen = 0;
  int     quiet_cycles = 0;
  bit     no_idle = 1'b0;
  bit     squeeze_phase = 1'b0;
  bit     squeeze_req = 1'b0;

  logic [12:0] setups [8][6];
  row_t        script [$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  nd_scatter_store #(
    .STORE_DEPTH(STORE_DEPTH),
    .ELEM_WIDTH (DEF_ELEM_WIDTH),
    .MAX_RANK   (DEF_MAX_RANK)
  ) uut (.*);

  task automatic log_miss(input string msg);
    miss_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic bit geometry_ok();
    if (geo_rank < 1 || geo_rank > DEF_MAX_RANK) return 1'b0;
    if (geo_depth < 1 || geo_depth > geo_rank) return 1'b0;
    for (int d = 0; d < geo_rank; d++)
      if (geo_dim[d] == 0) return 1'b0;
    return 1'b1;
  endfunction

  // Row-major stride: product of the extents after dimension d, within rank.
  function automatic longint unsigned dim_stride(input int d);
    longint unsigned s;
    s = 1;
    for (int k = d + 1; k < geo_rank; k++) s = s * geo_dim[k];
    return s;
  endfunction

  function automatic void store_elem(input int unsigned a, input logic [31:0] v);
    shadow_mem[a] = v;
    if (!mem_loaded[a]) begin
      mem_loaded[a] = 1'b1;
      loaded_list.push_back(a);
    end
  endfunction

  function automatic status_t scatter_code(input req_beat_t b);
    longint unsigned base, span;
    if (!geometry_ok()) return ST_INVALID;
    base = 0;
    for (int d = 0; d < geo_depth; d++) begin
      if (b.idx[d][63] || b.idx[d] >= geo_dim[d]) return ST_RANGE;
      base += b.idx[d] * dim_stride(d);
    end
    span = dim_stride(geo_depth - 1);
    // position is checked before the slice is bounded against the store
    if (b.pos >= span) return ST_INVALID;
    if (base + span > STORE_DEPTH) return ST_RANGE;
    store_elem(base + b.pos, b.val);
    return ST_DONE;
  endfunction

  // Flat addresses are 12 bits, so load and read always land inside the store.
  function automatic reply_t apply_request(input req_beat_t b);
    reply_t r;
    r.value = '0;
    r.code  = ST_DONE;
    case (b.kind)
      REQ_LOAD:    store_elem(b.addr, b.val);
      REQ_READ:    r.value = shadow_mem[b.addr];
      REQ_SCATTER: r.code = scatter_code(b);
      default:     r.code = ST_INVALID;
    endcase
    return r;
  endfunction

  function automatic void apply_cfg(input int r, input logic [12:0] data);
    case (r)
      CFG_DATA_RANK:   geo_rank = data[2:0];
      CFG_INDEX_DEPTH: geo_depth = data[2:0];
      default:         geo_dim[r - CFG_DIM0] = data;
    endcase
  endfunction

  task automatic program_setup(input logic [12:0] regs [6]);
    for (int r = CFG_DATA_RANK; r <= CFG_DIM3; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data  <= regs[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_cfg(r, regs[r]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (pending_reply.size() != 0) @(posedge clk);
  endtask

  task automatic issue_request(input req_beat_t b, input bit typed, input reply_t want);
    reply_t predicted;
    int gap;
    in_valid       <= 1'b1;
    req_type       <= b.kind;
    elem_address   <= b.addr;
    elem_value     <= b.val;
    index_0        <= b.idx[0];
    index_1        <= b.idx[1];
    index_2        <= b.idx[2];
    index_3        <= b.idx[3];
    slice_position <= b.pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_request(b);
    pending_reply.push_back(typed ? want : predicted);
    gap = (no_idle || squeeze_phase) ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic void draw_setup(output logic [12:0] regs [6]);
    int rank, depth, per_dim;
    rank    = $urandom_range(1, 4);
    depth   = $urandom_range(1, rank);
    per_dim = 1 << (12 / rank);
    // extents past the rank are noise the block must ignore
    for (int d = 0; d < 4; d++)
      regs[CFG_DIM0 + d] = (d < rank) ? $urandom_range(1, per_dim) : $urandom_range(0, 8191);
    case ($urandom_range(0, 9))
      8: regs[CFG_DIM0 + $urandom_range(0, rank - 1)] = $urandom_range(2048, 8191);
      9: begin
        case ($urandom_range(0, 3))
          0: rank = $urandom_range(0, 1) ? 0 : 8;
          1: rank = $urandom_range(5, 7);
          2: depth = $urandom_range(0, 1) ? 0 : $urandom_range(rank + 1, 7);
          default: regs[CFG_DIM0 + $urandom_range(0, rank - 1)] = '0;
        endcase
      end
      default: ;
    endcase
    regs[CFG_DATA_RANK]   = rank;
    regs[CFG_INDEX_DEPTH] = depth;
    // upper data bits fall outside the 3-bit fields
    if ($urandom_range(0, 3) == 0) regs[CFG_DATA_RANK] |= 13'h1FF8 & $urandom;
    if ($urandom_range(0, 3) == 0) regs[CFG_INDEX_DEPTH] |= 13'h1FF8 & $urandom;
  endfunction

  function automatic void shape_scatter(inout req_beat_t b);
    longint unsigned span;
    int d;
    b.kind = REQ_SCATTER;
    if (!geometry_ok()) begin
      for (int k = 0; k < 4; k++) b.idx[k] = $urandom_range(0, 15);
      return;
    end
    span = dim_stride(geo_depth - 1);
    for (int k = 0; k < geo_depth; k++) b.idx[k] = $urandom_range(0, geo_dim[k] - 1);
    b.pos = $urandom_range(0, (span > STORE_DEPTH) ? STORE_DEPTH - 1 : span - 1);
    if ($urandom_range(0, 3) != 0) return;
    d = $urandom_range(0, geo_depth - 1);
    case ($urandom_range(0, 3))
      0: b.idx[d] = {1'b1, $urandom, $urandom_range(0, 32'h7FFF_FFFF)};
      1: b.idx[d] = geo_dim[d] + $urandom_range(0, 3);
      2: b.idx[d] = {1'b0, $urandom_range(0, 32'h7FFF_FFFF), $urandom};
      default: begin
        if (span < STORE_DEPTH) b.pos = $urandom_range(span, STORE_DEPTH - 1);
        else b.idx[d] = NEG_ONE;
      end
    endcase
  endfunction

  function automatic req_beat_t draw_request();
    req_beat_t b;
    int pick;
    b.kind = REQ_LOAD;
    b.addr = $urandom_range(0, STORE_DEPTH - 1);
    b.val  = $urandom;
    for (int k = 0; k < 4; k++) b.idx[k] = {$urandom, $urandom};
    b.pos = $urandom_range(0, STORE_DEPTH - 1);
    pick  = $urandom_range(0, 99);
    if (pick >= 30 && pick < 60 && loaded_list.size() != 0) begin
      // read only what has been written
      b.kind = REQ_READ;
      if (!mem_loaded[b.addr]) b.addr = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    end else if (pick >= 60 && pick < 95) begin
      shape_scatter(b);
    end else if (pick >= 95) begin
      b.kind = REQ_BAD;
    end
    return b;
  endfunction

  // Receiver: may hold off after each beat; one long hold fills the block.
  initial begin
    int hold;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (squeeze_req) begin
          squeeze_req = 1'b0;
          hold = SQUEEZE_CYCLES;
        end else begin
          hold = no_idle ? 0 : $urandom_range(0, 9);
        end
        if (hold != 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      beats_seen++;
      if (pending_reply.size() == 0) begin
        log_miss($sformatf("beat %0d arrived with nothing outstanding", beats_seen));
      end else begin
        head_reply = pending_reply.pop_front();
        if (read_value !== head_reply.value)
          log_miss($sformatf("beat %0d read_value %h, predicted %h",
                             beats_seen, read_value, head_reply.value));
        if (status !== head_reply.code)
          log_miss($sformatf("beat %0d result code %0d, predicted %0d",
                             beats_seen, status, head_reply.code));
      end
    end
  end

  // Watchdog: count cycles in which no channel moves a beat.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int cur_setup;
    logic [12:0] regs [6];
    req_beat_t b;
    reply_t none;
    rst            <= 1'b1;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    req_type       <= '0;
    elem_address   <= '0;
    elem_value     <= '0;
    index_0        <= '0;
    index_1        <= '0;
    index_2        <= '0;
    index_3        <= '0;
    slice_position <= '0;
    none = '{32'h0, ST_DONE};

    setups = '{'{1, 1, 1, 1, 1, 1},        // reset shape
               '{4, 2, 4, 4, 16, 16},      // full store, 256-element slices
               '{2, 1, 8, 1024, 1, 1},     // slices can run past the store
               '{0, 1, 4, 4, 4, 4},        // rank zero
               '{2, 3, 4, 4, 4, 4},        // depth above rank
               '{3, 1, 4, 0, 4, 4},        // zero extent within rank
               '{1, 1, 4096, 1, 1, 1},     // largest single extent
               '{4, 4, 8, 8, 8, 8}};       // full depth, one-element slices

    script = '{
      '{0, '{REQ_LOAD, 12'd0, 32'hFFFF_FFFF, '{0, 0, 0, 0}, 12'd0}, 1, '{32'h0, ST_DONE}},
      '{0, '{REQ_READ, 12'd0, 32'h0, '{0, 0, 0, 0}, 12'd0}, 1, '{32'hFFFF_FFFF, ST_DONE}},
      '{0, '{REQ_LOAD, 12'hFFF, 32'h0, '{0, 0, 0, 0}, 12'd0}, 1, '{32'h0, ST_DONE}},
      '{0, '{REQ_READ, 12'hFFF, 32'h0, '{0, 0, 0, 0}, 12'd0}, 1, '{32'h0, ST_DONE}},
      '{0, '{REQ_SCATTER, 12'hFFF, 32'hA5A5_5A5A, '{0, NEG_ONE, NEG_ONE, NEG_ONE}, 12'd0},
        1, '{32'h0, ST_DONE}},
      '{0, '{REQ_READ, 12'd0, 32'h0, '{0, 0, 0, 0}, 12'd0}, 1, '{32'hA5A5_5A5A, ST_DONE}},
      '{0, '{REQ_SCATTER, 12'd0, 32'h1, '{MOST_NEG, 0, 0, 0}, 12'd0}, 1, '{32'h0, ST_RANGE}},
      '{0, '{REQ_SCATTER, 12'd0, 32'h1, '{MOST_POS, 0, 0, 0}, 12'd0}, 1, '{32'h0, ST_RANGE}},
      '{0, '{REQ_SCATTER, 12'd0, 32'h1, '{0, 0, 0, 0}, 12'hFFF}, 1, '{32'h0, ST_INVALID}},
      '{0, '{REQ_BAD, 12'd0, 32'hFFFF_FFFF, '{0, 0, 0, 0}, 12'd0}, 1, '{32'h0, ST_INVALID}},
      '{0, '{REQ_LOAD, 12'hAAA, 32'h5555_5555, '{0, 0, 0, 0}, 12'd0}, 1, '{32'h0, ST_DONE}},
      '{0, '{REQ_READ, 12'hAAA, 32'h0, '{0, 0, 0, 0}, 12'd0}, 1, '{32'h5555_5555, ST_DONE}},
      '{1, '{REQ_SCATTER, 12'd0, 32'h3C3C_C3C3, '{3, 3, MOST_NEG, MOST_POS}, 12'd255},
        1, '{32'h0, ST_DONE}},
      '{1, '{REQ_READ, 12'hFFF, 32'h0, '{0, 0, 0, 0}, 12'd0}, 1, '{32'h3C3C_C3C3, ST_DONE}},
      '{1, '{REQ_SCATTER, 12'd0, 32'h1, '{3, 4, 0, 0}, 12'd0}, 1, '{32'h0, ST_RANGE}},
      '{1, '{REQ_SCATTER, 12'd0, 32'h1, '{0, 0, 0, 0}, 12'd256}, 1, '{32'h0, ST_INVALID}},
      '{1, '{REQ_SCATTER, 12'd0, 32'h1, '{0, NEG_ONE, 0, 0}, 12'd0}, 1, '{32'h0, ST_RANGE}},
      '{2, '{REQ_SCATTER, 12'd0, 32'h1, '{4, 0, 0, 0}, 12'd0}, 1, '{32'h0, ST_RANGE}},
      '{2, '{REQ_SCATTER, 12'd0, 32'h0F0F_F0F0, '{3, 0, 0, 0}, 12'd1023}, 0, none},
      '{3, '{REQ_SCATTER, 12'd0, 32'h1, '{0, 0, 0, 0}, 12'd0}, 1, '{32'h0, ST_INVALID}},
      '{3, '{REQ_LOAD, 12'd1, 32'h1234_5678, '{0, 0, 0, 0}, 12'd0}, 1, '{32'h0, ST_DONE}},
      '{4, '{REQ_SCATTER, 12'd0, 32'h1, '{0, 0, 0, 0}, 12'd0}, 1, '{32'h0, ST_INVALID}},
      '{5, '{REQ_SCATTER, 12'd0, 32'h1, '{0, 0, 0, 0}, 12'd0}, 1, '{32'h0, ST_INVALID}},
      '{6, '{REQ_SCATTER, 12'd0, 32'h8000_0001, '{4095, 0, 0, 0}, 12'd0}, 0, none},
      '{6, '{REQ_SCATTER, 12'd0, 32'h1, '{4096, 0, 0, 0}, 12'd0}, 1, '{32'h0, ST_RANGE}}};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    cur_setup = 0;
    foreach (script[i]) begin
      if (script[i].setup != cur_setup) begin
        drain_replies();
        program_setup(setups[script[i].setup]);
        cur_setup = script[i].setup;
      end
      issue_request(script[i].beat, script[i].typed, script[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_replies();
      if (p == 0) regs = setups[7];
      else if (p == 1) regs = setups[6];
      else draw_setup(regs);
      program_setup(regs);
      no_idle       = (p % 4 == 2);
      squeeze_phase = (p == SQUEEZE_PHASE);
      squeeze_req   = squeeze_phase;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        b = draw_request();
        issue_request(b, 1'b0, none);
      end
    end
    no_idle       = 1'b0;
    squeeze_phase = 1'b0;

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (miss_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
